@@ src/leb128_stream_decoder_macros.svh @@
// assertion macros shared by the leb128 stream decoder rtl
// depends on a clock named clk and a synchronous reset named rst in the using module
`ifndef LEB128_STREAM_DECODER_MACROS_SVH
`define LEB128_STREAM_DECODER_MACROS_SVH

`ifndef SYNTHESIS

`define LEB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("leb128 decoder check failed");

`define LEB_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

`else

`define LEB_ASSERT(lbl, prop)

`define LEB_ASSERT_MSG(lbl, prop, msg)

`endif

`endif

@@ src/leb_pkg.sv @@
// types, constants and helpers for the leb128 stream decoder
// no dependencies
package leb_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] MODE_U32 = 2'd0;
  localparam logic [1:0] MODE_S32 = 2'd1;
  localparam logic [1:0] MODE_U64 = 2'd2;
  localparam logic [1:0] MODE_S64 = 2'd3;

  localparam logic [3:0] LIMIT_32 = 4'd5;
  localparam logic [3:0] LIMIT_64 = 4'd10;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [63:0] value;
    logic        error;
    logic [3:0]  bytes_used;
  } out_item_t;

  // one classified byte on its way from front to back
  typedef struct packed {
    logic [6:0] payload;
    logic [3:0] pos;
    logic [1:0] mode;
    logic       done;
    logic       err;
  } mid_t;

  // bit position 7*n
  function automatic logic [6:0] pos7(input logic [3:0] n);
    return {n, 3'b000} - {3'b000, n};
  endfunction

endpackage

@@ src/leb_front.sv @@
// front end: accepts bytes, tracks byte count and mode, classifies each byte
// depends on leb_pkg
`include "leb128_stream_decoder_macros.svh"

module leb_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  leb_pkg::in_item_t item,
  input  logic            q_full,
  output logic            q_wr,
  output leb_pkg::mid_t   q_data
);
  import leb_pkg::*;

  logic [3:0] cnt;
  logic [3:0] cnt_next;
  logic [1:0] mode;
  logic [1:0] mode_eff;
  logic [3:0] cnt1;
  logic [3:0] limit;
  logic       done;
  logic       err;

  assign full = q_full;
  assign q_wr = push && !q_full;

  always_comb begin
    mode_eff = (cnt == 4'd0) ? item.func : mode;
    limit    = mode_eff[1] ? LIMIT_64 : LIMIT_32;
    cnt1     = cnt + 4'd1;
    done     = !item.data_byte[7] || (cnt1 >= limit);
    err      = !done && item.end_of_data;
    cnt_next = (done || err) ? 4'd0 : cnt1;
  end

  always_comb begin
    q_data.payload = item.data_byte[6:0];
    q_data.pos     = cnt;
    q_data.mode    = mode_eff;
    q_data.done    = done;
    q_data.err     = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= 4'd0;
      mode <= MODE_U32;
    end else if (q_wr) begin
      cnt  <= cnt_next;
      mode <= mode_eff;
    end
  end

  `LEB_ASSERT_MSG(a_cnt_range, cnt <= 4'd9, "byte count past 64-bit limit")
  `LEB_ASSERT_MSG(a_cnt_32, !(cnt != 4'd0 && !mode[1] && cnt > 4'd4),
                  "byte count past 32-bit limit")

endmodule

@@ src/leb_queue.sv @@
// short queue of classified bytes between front and back
// depends on leb_pkg
`include "leb128_stream_decoder_macros.svh"

module leb_queue #(
  parameter int DEPTH = leb_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  leb_pkg::mid_t wdata,
  output logic          q_full,
  input  logic          rd,
  output logic          q_empty,
  output leb_pkg::mid_t rdata
);
  import leb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  mid_t          slots [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] cnt;

  assign q_full  = (cnt == CW'(DEPTH));
  assign q_empty = (cnt == '0);
  assign rdata   = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == LAST) ? '0 : wptr + PW'(1);
      end
      if (rd) begin
        rptr <= (rptr == LAST) ? '0 : rptr + PW'(1);
      end
      if (wr && !rd) begin
        cnt <= cnt + CW'(1);
      end else if (rd && !wr) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  `LEB_ASSERT(a_q_fill, (wr && !rd) |=> cnt == $past(cnt) + CW'(1))
  `LEB_ASSERT(a_q_drain, (rd && !wr) |=> cnt == $past(cnt) - CW'(1))

endmodule

@@ src/leb_back.sv @@
// back end: accumulates payload, finishes numbers, holds the result register
// depends on leb_pkg
`include "leb128_stream_decoder_macros.svh"

module leb_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  leb_pkg::mid_t     q_data,
  output logic              rd,
  output logic              empty,
  input  logic              pop,
  output leb_pkg::out_item_t result
);
  import leb_pkg::*;

  logic [63:0] acc;
  logic [63:0] acc_next;
  logic [3:0]  cnt1;
  logic [6:0]  top;
  logic [63:0] v;
  logic [63:0] fin;
  logic        ext;
  logic        finish;
  logic        res_valid;
  logic        slot_free;
  out_item_t   res;
  out_item_t   res_next;

  always_comb begin
    acc_next = ((q_data.pos == 4'd0) ? 64'd0 : acc) |
               ({57'd0, q_data.payload} << pos7(q_data.pos));
    cnt1 = q_data.pos + 4'd1;
    top  = pos7(cnt1) - 7'd1;
    v    = q_data.mode[1] ? acc_next : {32'd0, acc_next[31:0]};
    // signed modes extend from the last payload bit when it lies below the top bit
    ext  = q_data.mode[0] && (q_data.mode[1] ? (cnt1 <= 4'd9) : (cnt1 <= 4'd4));
    fin  = v;
    if (ext && |(v & (64'd1 << top))) begin
      fin = v | (~64'd0 << top);
      if (!q_data.mode[1]) begin
        fin[63:32] = 32'd0;
      end
    end
    res_next.value      = q_data.done ? fin : 64'd0;
    res_next.error      = !q_data.done;
    res_next.bytes_used = cnt1;
  end

  assign finish    = q_data.done || q_data.err;
  assign slot_free = !res_valid || pop;
  assign rd        = !q_empty && (!finish || slot_free);
  assign empty     = !res_valid;
  assign result    = res;

  always_ff @(posedge clk) begin
    if (rd) begin
      acc <= acc_next;
    end
    if (rd && finish) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (rd && finish) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  `LEB_ASSERT_MSG(a_err_zero, (res_valid && res.error) |-> res.value == 64'd0,
                  "error result with nonzero value")
  `LEB_ASSERT_MSG(a_used_range,
                  res_valid |-> (res.bytes_used >= 4'd1 && res.bytes_used <= 4'd10),
                  "bytes used out of range")

endmodule

@@ src/leb128_stream_decoder.sv @@
// LEB128 stream decoder: takes one encoded byte per cycle, while full is low, through a
// queue-style push/full port and returns one result per integer, finished or cut off by
// end_of_data, through an empty/pop port. The mode (u32, s32, u64, s64) comes from func
// on the first byte of each number. A byte is classified in the cycle it is pushed,
// waits in a short queue (QDEPTH entries) and is folded into the accumulator by the back
// end; a result is written from the queue slot into the result register once nothing
// waits ahead of it. A single result register feeds the output; while a result sits
// unpopped the back end can still absorb continuation bytes, and the front keeps taking
// bytes until the queue fills.
// Depends on leb_pkg, leb_front, leb_queue and leb_back.
module leb128_stream_decoder #(
  parameter int QDEPTH = leb_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  leb_pkg::in_item_t  item,
  output logic               empty,
  input  logic               pop,
  output leb_pkg::out_item_t result
);
  import leb_pkg::*;

  logic q_full;
  logic q_wr;
  logic q_empty;
  logic q_rd;
  mid_t q_wdata;
  mid_t q_rdata;

  leb_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_full (q_full),
    .q_wr   (q_wr),
    .q_data (q_wdata)
  );

  leb_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wdata   (q_wdata),
    .q_full  (q_full),
    .rd      (q_rd),
    .q_empty (q_empty),
    .rdata   (q_rdata)
  );

  leb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .rd      (q_rd),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

@@ sim/leb128_stream_decoder_tb.sv @@
// self-checking testbench for leb128_stream_decoder: byte stream in, decoded numbers out
// depends on leb_pkg and the decoder rtl; holds its own decoder model in a scoreboard class
module leb128_stream_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import leb_pkg::*;

  localparam int NUM_REQUESTS = 1250;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;

  class number_scoreboard;
    logic [63:0] acc;
    logic [3:0]  cnt;
    logic [1:0]  mode;
    out_item_t   numbers_due[$];
    int          errors;

    function new();
      acc = '0;
      cnt = '0;
      mode = MODE_U32;
      errors = 0;
    endfunction

    // value at mode width, signed modes extended from the last payload bit
    function logic [63:0] finished_value();
      logic [63:0] v;
      int          top;
      int          width;
      bit          wide;
      bit          signed_mode;
      wide = (mode == MODE_U64 || mode == MODE_S64);
      signed_mode = (mode == MODE_S32 || mode == MODE_S64);
      width = wide ? 64 : 32;
      top = 7 * cnt - 1;
      v = wide ? acc : {32'd0, acc[31:0]};
      if (signed_mode && top < width - 1 && v[top]) begin
        v |= ~64'd0 << top;
        if (!wide) v[63:32] = '0;
      end
      return v;
    endfunction

    function void note_byte(in_item_t it);
      out_item_t   num;
      logic [3:0]  lim;
      bit          fin;
      if (cnt == 0) begin
        mode = it.func;
        acc = '0;
      end
      lim = (mode == MODE_U64 || mode == MODE_S64) ? LIMIT_64 : LIMIT_32;
      if (cnt < LIMIT_64) acc |= 64'(it.data_byte[6:0]) << (7 * cnt);
      cnt = cnt + 4'd1;
      fin = !it.data_byte[7] || cnt >= lim;
      if (fin || it.end_of_data) begin
        num.value = fin ? finished_value() : 64'd0;
        num.error = !fin;
        num.bytes_used = cnt;
        numbers_due.push_back(num);
        acc = '0;
        cnt = '0;
      end
    endfunction

    function void check_number(out_item_t r);
      out_item_t want;
      if (numbers_due.size() == 0) begin
        $error("unexpected result: value %h error %0d bytes_used %0d",
               r.value, r.error, r.bytes_used);
        errors++;
        return;
      end
      want = numbers_due.pop_front();
      if (r.value !== want.value) begin
        $error("value: expected %h, got %h", want.value, r.value);
        errors++;
      end
      if (r.error !== want.error) begin
        $error("error: expected %0d, got %0d", want.error, r.error);
        errors++;
      end
      if (r.bytes_used !== want.bytes_used) begin
        $error("bytes_used: expected %0d, got %0d", want.bytes_used, r.bytes_used);
        errors++;
      end
    endfunction

    function int pending();
      return numbers_due.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      full;
  in_item_t  item = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t result;

  number_scoreboard sb = new();
  int send_idle = 6;
  int recv_idle = 73;
  int n_sent = 0;
  int cycles = 0;

  leb128_stream_decoder u_top (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: check on every accepted pop, then pick the next pop at random
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) sb.check_number(result);
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  // push stays high between back-to-back requests; lowered only for idle cycles
  task automatic send_item(input logic [1:0] func, input logic [7:0] data, input logic eod);
    in_item_t it;
    it.func = func;
    it.data_byte = data;
    it.end_of_data = eod;
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_byte(it);
    n_sent++;
  endtask

  function automatic logic [6:0] pick_payload();
    case ($urandom_range(3))
      0: return 7'h00;
      1: return 7'h7f;
      default: return 7'($urandom);
    endcase
  endfunction

  // one number in a random mode; broken numbers end the data on a continuation byte
  task automatic send_number(input bit broken);
    logic [1:0] mode;
    logic [7:0] data;
    logic       eod;
    int         lim;
    int         len;
    mode = 2'($urandom);
    lim = (mode == MODE_U64 || mode == MODE_S64) ? int'(LIMIT_64) : int'(LIMIT_32);
    len = broken ? $urandom_range(1, lim - 1) : $urandom_range(1, lim);
    for (int i = 0; i < len; i++) begin
      data = {1'b1, pick_payload()};
      eod = 1'b0;
      if (i == len - 1) begin
        if (broken) eod = 1'b1;
        else begin
          if (len < lim) data[7] = 1'b0;
          else data[7] = 1'($urandom);
          eod = ($urandom_range(7) == 0);
        end
      end
      send_item(i == 0 ? mode : 2'($urandom), data, eod);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // single-byte numbers in every mode, sign bit set and clear
    send_item(MODE_U32, 8'h00, 1'b0);
    send_item(MODE_S32, 8'h7f, 1'b0);
    send_item(MODE_U64, 8'h7f, 1'b0);
    send_item(MODE_S64, 8'h40, 1'b0);
    // u32 hits the byte limit with the continuation bit still set
    repeat (5) send_item(MODE_U32, 8'hff, 1'b0);
    // s64 at the byte limit, func changing on later bytes
    send_item(MODE_S64, 8'hff, 1'b0);
    for (int i = 1; i < 10; i++) send_item(2'(i), 8'hff, 1'b0);
    // data ends with a continuation pending
    send_item(MODE_S32, 8'h80, 1'b1);
    // data ends on the final byte of a number
    send_item(MODE_U64, 8'h85, 1'b0);
    send_item(MODE_U64, 8'h01, 1'b1);
    // short negative s32
    send_item(MODE_S32, 8'hff, 1'b0);
    send_item(MODE_S32, 8'h7f, 1'b0);

    // hold off until the decoder has drained
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);

    while (n_sent < NUM_REQUESTS) begin
      if (n_sent > NUM_REQUESTS * 2 / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end else if (n_sent > NUM_REQUESTS / 3) begin
        send_idle = 73;
        recv_idle = 6;
      end
      case ($urandom_range(9))
        0: send_item(2'($urandom), 8'($urandom), 1'($urandom));
        1: send_number(1'b1);
        default: send_number(1'b0);
      endcase
    end
    push <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ leb128_stream_decoder.f @@
+incdir+src
src/leb_pkg.sv
src/leb_front.sv
src/leb_queue.sv
src/leb_back.sv
src/leb128_stream_decoder.sv
sim/leb128_stream_decoder_tb.sv
